// ===== rtl/pidc_pkg.sv =====
// Package for the PID heat/cool PWM controller: widths, reset values,
// register indexes, state and term codes, and the multiplier request/response.
// No dependencies.
package pidc_pkg;

  // Field and datapath widths
  localparam int TEMP_W     = 15;
  localparam int ERR_W      = 15;
  localparam int DIFF_W     = 16;
  localparam int SUM_W      = 48;
  localparam int GAIN_W     = 31;
  localparam int LIMIT_W    = 31;
  localparam int PERIOD_W   = 32;
  localparam int DRIVE_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_A_W    = 48;
  localparam int MUL_B_W    = 32;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int CAP_W      = 61;
  localparam int ACC_W      = 63;
  localparam int Q16_W      = ACC_W - 16;

  // Register reset values
  localparam logic signed [TEMP_W-1:0] SETPOINT_RST   = 15'sd3000;
  localparam logic [GAIN_W-1:0]        GAIN_PROP_RST  = 31'd8589935;
  localparam logic [GAIN_W-1:0]        GAIN_INTEG_RST = 31'd858993;
  localparam logic [GAIN_W-1:0]        GAIN_DERIV_RST = 31'd4294967;
  localparam logic [LIMIT_W-1:0]       LIMIT_RST      = 31'd786432;
  localparam logic [PERIOD_W-1:0]      PERIOD_RST     = 32'd666666;

  // Saturation bounds
  localparam logic [ERR_W-1:0] ERR_MAX = 15'h3FFF;
  localparam logic [ERR_W-1:0] ERR_MIN = 15'h4000;
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [CAP_W-1:0] PROD_CAP = {1'b1, {(CAP_W-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_GAIN_PROP  = 3'd1,
    REG_GAIN_INTEG = 3'd2,
    REG_GAIN_DERIV = 3'd3,
    REG_LIMIT      = 3'd4,
    REG_PERIOD     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] setpoint;
    logic [GAIN_W-1:0]        gain_prop;
    logic [GAIN_W-1:0]        gain_integ;
    logic [GAIN_W-1:0]        gain_deriv;
    logic [LIMIT_W-1:0]       limit;
    logic [PERIOD_W-1:0]      period;
  } cfg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_INTEG,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_CLAMP,
    ST_DONE
  } state_t;

  // Product being formed by the shared multiplier
  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D,
    TERM_DUTY
  } term_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

endpackage

// ===== rtl/pidc_cfg_regs.sv =====
// Configuration register file of the PID controller.
// Depends on pidc_pkg (cfg_t, register indexes, reset values).
module pidc_cfg_regs import pidc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  // One write per cycle; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint   <= SETPOINT_RST;
      cfg.gain_prop  <= GAIN_PROP_RST;
      cfg.gain_integ <= GAIN_INTEG_RST;
      cfg.gain_deriv <= GAIN_DERIV_RST;
      cfg.limit      <= LIMIT_RST;
      cfg.period     <= PERIOD_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SETPOINT:   cfg.setpoint   <= wr_data[TEMP_W-1:0];
        REG_GAIN_PROP:  cfg.gain_prop  <= wr_data[GAIN_W-1:0];
        REG_GAIN_INTEG: cfg.gain_integ <= wr_data[GAIN_W-1:0];
        REG_GAIN_DERIV: cfg.gain_deriv <= wr_data[GAIN_W-1:0];
        REG_LIMIT:      cfg.limit      <= wr_data[LIMIT_W-1:0];
        REG_PERIOD:     cfg.period     <= wr_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/pidc_sermul.sv =====
// Radix-2 serial multiplier: one multiplier bit per cycle, product low bits
// shift out of the adder into a shift register. Depends on pidc_pkg.
module pidc_sermul import pidc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CNT_W = $clog2(MUL_B_W);

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   count;
  logic [MUL_A_W-1:0] a_q;
  logic [MUL_A_W-1:0] hi;
  logic [MUL_B_W-1:0] lo;
  logic [MUL_A_W:0]   sum;

  // Partial product add, one bit wider than the multiplicand for the carry
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a_q} : '0);

  // Step counter and status
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift-add datapath; lo holds the remaining multiplier bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_q <= req.a;
      hi  <= '0;
      lo  <= req.b;
    end else if (busy) begin
      hi <= sum[MUL_A_W:1];
      lo <= {sum[0], lo[MUL_B_W-1:1]};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.prod = {hi, lo};

  // A new product only starts on an idle unit
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("multiplier started while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |=> busy) else $error("multiplier did not go busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy)) else $error("done without a finished run");

endmodule

// ===== rtl/pid_heat_cool_pwm_controller.sv =====
// PID heat/cool PWM controller, top level.
// A primed good sample passes ST_ERR, ST_INTEG, four passes through the shared
// serial multiplier (P, I, D, and after ST_CLAMP the duty product, one bit per
// cycle) and ST_DONE; a first good sample only primes, a failed read is
// dropped. The next item is taken once the result sits in the output register.
// Synchronous reset clears the control state, integrator and config registers.
module pid_heat_cool_pwm_controller import pidc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,    // [14:0] temperature_centi
  input  logic [0:0]            s_tuser,    // [0] read_failed
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [95:0]           m_tdata,    // [31:0] drive, [63:32] heat_duty,
                                            // [95:64] cool_duty
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  mul_req_t mreq;
  mul_rsp_t mrsp;

  state_t state, state_next;
  term_t  term, term_next;
  logic   mul_start;
  logic   load_out;

  logic signed [TEMP_W-1:0] temp_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [ERR_W-1:0]  prev_err;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [SUM_W-1:0]  error_sum;
  logic                     primed;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DRIVE_W-1:0] drive_q;

  logic [DRIVE_W-1:0]  out_drive;
  logic [PERIOD_W-1:0] out_heat;
  logic [PERIOD_W-1:0] out_cool;

  assign cfg_ready = 1'b1;

  pidc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Error, saturated to 15 bits
  logic [ERR_W:0]     err_wide;
  logic [ERR_W-1:0]   err_sat;
  assign err_wide = {cfg.setpoint[TEMP_W-1], cfg.setpoint} - {temp_q[TEMP_W-1], temp_q};
  assign err_sat  = (err_wide[ERR_W] != err_wide[ERR_W-1]) ?
                    (err_wide[ERR_W] ? ERR_MIN : ERR_MAX) : err_wide[ERR_W-1:0];

  // Integrator update with saturation, and error difference
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_sat;
  logic [DIFF_W-1:0]   diff;
  assign sum_wide = {error_sum[SUM_W-1], error_sum}
                  + {{(SUM_W-ERR_W+1){err_q[ERR_W-1]}}, err_q};
  assign sum_sat  = (sum_wide[SUM_W] != sum_wide[SUM_W-1]) ?
                    (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX) : sum_wide[SUM_W-1:0];
  assign diff     = {err_q[ERR_W-1], err_q} - {prev_err[ERR_W-1], prev_err};

  // Drive magnitude for the duty product
  logic [DRIVE_W-1:0] drive_abs;
  assign drive_abs = drive_q[DRIVE_W-1] ? (DRIVE_W'(0) - drive_q) : drive_q;

  // Multiplier operands: signed value split into sign and magnitude
  logic [MUL_A_W-1:0] op_val;
  logic [MUL_B_W-1:0] op_gain;
  logic               op_neg;
  logic [MUL_A_W-1:0] op_mag;
  always_comb begin
    unique case (term)
      TERM_P: begin
        op_val  = {{(MUL_A_W-ERR_W){err_q[ERR_W-1]}}, err_q};
        op_gain = {1'b0, cfg.gain_prop};
      end
      TERM_I: begin
        op_val  = error_sum;
        op_gain = {1'b0, cfg.gain_integ};
      end
      TERM_D: begin
        op_val  = {{(MUL_A_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
        op_gain = {1'b0, cfg.gain_deriv};
      end
      TERM_DUTY: begin
        op_val  = {{(MUL_A_W-DRIVE_W+1){1'b0}}, drive_abs[DRIVE_W-2:0]};
        op_gain = cfg.period;
      end
      default: begin
        op_val  = '0;
        op_gain = '0;
      end
    endcase
  end
  assign op_neg = op_val[MUL_A_W-1];
  assign op_mag = op_neg ? (MUL_A_W'(0) - op_val) : op_val;

  assign mreq.start = mul_start;
  assign mreq.a     = op_mag;
  assign mreq.b     = op_gain;

  pidc_sermul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // Gain product capped at 2^60, sign restored
  logic [CAP_W-1:0] capped;
  logic [ACC_W-1:0] term_val;
  assign capped   = (|mrsp.prod[MUL_P_W-1:CAP_W-1]) ? PROD_CAP : mrsp.prod[CAP_W-1:0];
  assign term_val = op_neg ? (ACC_W'(0) - {2'b00, capped}) : {2'b00, capped};

  // Q32 to Q16 by floor, then symmetric clamp
  logic signed [Q16_W-1:0] q16;
  logic signed [Q16_W-1:0] lim_pos;
  logic signed [Q16_W-1:0] lim_neg;
  logic signed [Q16_W-1:0] q16_clamped;
  assign q16     = acc[ACC_W-1:16];
  assign lim_pos = {{(Q16_W-LIMIT_W){1'b0}}, cfg.limit};
  assign lim_neg = Q16_W'(0) - lim_pos;
  always_comb begin
    priority if (q16 > lim_pos) q16_clamped = lim_pos;
    else if (q16 < lim_neg)     q16_clamped = lim_neg;
    else                        q16_clamped = q16;
  end

  // Duty = |drive| * period >> 16, capped at the period
  logic [MUL_P_W-17:0] duty_wide;
  logic [PERIOD_W-1:0] duty;
  assign duty_wide = mrsp.prod[MUL_P_W-1:16];
  assign duty      = (duty_wide > {{(MUL_P_W-16-PERIOD_W){1'b0}}, cfg.period}) ?
                     cfg.period : duty_wide[PERIOD_W-1:0];

  // Order of the gain terms
  always_comb begin
    unique case (term)
      TERM_P:  term_next = TERM_I;
      TERM_I:  term_next = TERM_D;
      default: term_next = TERM_DUTY;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mul_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && !s_tuser[0]) state_next = ST_ERR;
      end
      ST_ERR:   state_next = primed ? ST_INTEG : ST_IDLE;
      ST_INTEG: state_next = ST_MUL_GO;
      ST_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mrsp.done) begin
          priority if (term == TERM_DUTY) state_next = ST_DONE;
          else if (term == TERM_D)        state_next = ST_CLAMP;
          else                            state_next = ST_MUL_GO;
        end
      end
      ST_CLAMP: state_next = ST_MUL_GO;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller state kept across items
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err  <= '0;
      error_sum <= '0;
      primed    <= 1'b0;
      term      <= TERM_P;
    end else begin
      if (state == ST_ERR && !primed) begin
        prev_err <= err_sat;
        primed   <= 1'b1;
      end
      if (state == ST_INTEG) begin
        error_sum <= sum_sat;
        prev_err  <= err_q;
        term      <= TERM_P;
      end
      if (state == ST_MUL_WAIT && mrsp.done && term != TERM_DUTY) term <= term_next;
      if (state == ST_CLAMP) term <= TERM_DUTY;
    end
  end

  // Working registers of one item
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) temp_q <= s_tdata[TEMP_W-1:0];
    if (state == ST_ERR) err_q <= err_sat;
    if (state == ST_INTEG) begin
      diff_q <= diff;
      acc    <= '0;
    end
    if (state == ST_MUL_WAIT && mrsp.done && term != TERM_DUTY) acc <= acc + term_val;
    if (state == ST_CLAMP) drive_q <= q16_clamped[DRIVE_W-1:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)           m_tvalid <= 1'b0;
    else if (load_out) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_drive <= drive_q;
      out_heat  <= drive_q[DRIVE_W-1] ? '0 : duty;
      out_cool  <= drive_q[DRIVE_W-1] ? duty : '0;
    end
  end

  assign m_tdata = {out_cool, out_heat, out_drive};

  // A waiting result is never overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_tvalid && !m_tready) |=> (state == ST_DONE))
    else $error("result overwritten while stalled");

  a_one_channel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_heat == '0 || out_cool == '0))
    else $error("heat and cool both driven");

  a_drive_clamped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (($signed({out_drive[DRIVE_W-1], out_drive}) <= $signed({2'b00, cfg.limit}))
               && ($signed({out_drive[DRIVE_W-1], out_drive})
                   >= -$signed({2'b00, cfg.limit}))))
    else $error("drive outside limit");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> (state == ST_MUL_WAIT))
    else $error("product finished outside wait state");

endmodule

// ===== sim/pid_heat_cool_pwm_controller_tb.sv =====
// Self-checking testbench for the PID heat/cool PWM controller: drives samples and
// register writes over the stream and config channels and checks each result.
// Depends on rtl/pidc_pkg.sv and rtl/pid_heat_cool_pwm_controller.sv.

// Predicts controller results and checks the results that come out
class pid_scoreboard;
  typedef struct {
    logic [31:0] drive;
    logic [31:0] heat;
    logic [31:0] cool;
  } duty_set_t;

  // register copies
  int          setpoint;
  logic [30:0] kp;
  logic [30:0] ki;
  logic [30:0] kd;
  logic [30:0] limit;
  logic [31:0] period;

  // controller state copies
  int          last_err;
  longint      err_total;
  bit          primed;

  duty_set_t   pending_q[$];

  int mismatches;
  int results_seen;
  int samples_taken;
  int skipped_reads;
  int saturated_errs;
  int clamped_drives;

  function new();
    setpoint  = int'(pidc_pkg::SETPOINT_RST);
    kp        = pidc_pkg::GAIN_PROP_RST;
    ki        = pidc_pkg::GAIN_INTEG_RST;
    kd        = pidc_pkg::GAIN_DERIV_RST;
    limit     = pidc_pkg::LIMIT_RST;
    period    = pidc_pkg::PERIOD_RST;
    last_err  = 0;
    err_total = 0;
    primed    = 1'b0;
  endfunction

  function void write_reg(logic [pidc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    case (idx)
      pidc_pkg::REG_SETPOINT:   setpoint = int'($signed(value[14:0]));
      pidc_pkg::REG_GAIN_PROP:  kp = value[30:0];
      pidc_pkg::REG_GAIN_INTEG: ki = value[30:0];
      pidc_pkg::REG_GAIN_DERIV: kd = value[30:0];
      pidc_pkg::REG_LIMIT:      limit = value[30:0];
      pidc_pkg::REG_PERIOD:     period = value;
      default: ;
    endcase
  endfunction

  // gain * value with the magnitude capped at 2^60
  function longint weighted(logic [30:0] gain, longint value);
    logic [95:0] mag;
    logic [95:0] prod;
    mag = (value < 0) ? 96'(-value) : 96'(value);
    prod = mag * gain;
    if (prod > pidc_pkg::PROD_CAP) prod = pidc_pkg::PROD_CAP;
    return (value < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // |drive| * period / 2^16, never above the period
  function logic [31:0] duty(logic [31:0] mag);
    logic [63:0] full;
    full = ({32'd0, mag} * {32'd0, period}) >> 16;
    return (full > {32'd0, period}) ? period : full[31:0];
  endfunction

  // Accepted input item: update state and queue the expected result
  function void note_sample(logic [14:0] temp_bits, bit failed);
    int        err;
    int        step;
    longint    acc;
    longint    q16;
    longint    lim;
    longint    mag;
    duty_set_t r;
    samples_taken++;
    if (failed) begin
      skipped_reads++;
      return;
    end
    err = setpoint - int'($signed(temp_bits));
    if (err > int'($signed(pidc_pkg::ERR_MAX))) begin
      err = int'($signed(pidc_pkg::ERR_MAX));
      saturated_errs++;
    end else if (err < int'($signed(pidc_pkg::ERR_MIN))) begin
      err = int'($signed(pidc_pkg::ERR_MIN));
      saturated_errs++;
    end
    // first good sample only seeds the derivative
    if (!primed) begin
      last_err = err;
      primed = 1'b1;
      return;
    end
    err_total = err_total + err;
    if (err_total > longint'($signed(pidc_pkg::SUM_MAX)))
      err_total = longint'($signed(pidc_pkg::SUM_MAX));
    if (err_total < longint'($signed(pidc_pkg::SUM_MIN)))
      err_total = longint'($signed(pidc_pkg::SUM_MIN));
    step = err - last_err;
    last_err = err;
    acc = weighted(kp, err) + weighted(ki, err_total) + weighted(kd, step);
    // Q32 to Q16, rounding toward minus infinity
    q16 = acc >>> 16;
    lim = limit;
    if (q16 > lim || q16 < -lim) clamped_drives++;
    if (q16 > lim) q16 = lim;
    if (q16 < -lim) q16 = -lim;
    r.drive = q16[31:0];
    if (q16 >= 0) begin
      r.heat = duty(q16[31:0]);
      r.cool = 32'd0;
    end else begin
      mag = -q16;
      r.heat = 32'd0;
      r.cool = duty(mag[31:0]);
    end
    pending_q.push_back(r);
  endfunction

  // Accepted result item: compare with the oldest expectation
  function void check_result(logic [95:0] data);
    duty_set_t want;
    duty_set_t got;
    got.drive = data[31:0];
    got.heat  = data[63:32];
    got.cool  = data[95:64];
    results_seen++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result drive=%0d heat=%0d cool=%0d", $time,
                 $signed(got.drive), got.heat, got.cool);
      return;
    end
    want = pending_q.pop_front();
    if (got.drive !== want.drive || got.heat !== want.heat || got.cool !== want.cool) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result %0d mismatch: drive %0d/%0d heat %0d/%0d cool %0d/%0d",
                 $time, results_seen, $signed(want.drive), $signed(got.drive),
                 want.heat, got.heat, want.cool, got.cool);
    end
  endfunction
endclass

module pid_heat_cool_pwm_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pidc_pkg::*;

  // indexes beyond the register map; writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 200;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 108;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [15:0]           s_tdata;   // [14:0] temperature_centi
  logic [0:0]            s_tuser;   // [0] read_failed
  logic                  m_tvalid;
  logic                  m_tready;
  logic [95:0]           m_tdata;   // [31:0] drive, [63:32] heat_duty, [95:64] cool_duty
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pid_scoreboard sb;
  bit            quiet;
  int            settings_done;
  int            temp_walk;

  pid_heat_cool_pwm_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Register write; called and returns at a falling edge
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_all(input logic [31:0] sp, input logic [31:0] p, input logic [31:0] i,
                           input logic [31:0] d, input logic [31:0] lim,
                           input logic [31:0] per);
    program_reg(REG_SETPOINT, sp);
    program_reg(REG_GAIN_PROP, p);
    program_reg(REG_GAIN_INTEG, i);
    program_reg(REG_GAIN_DERIV, d);
    program_reg(REG_LIMIT, lim);
    program_reg(REG_PERIOD, per);
    // occasionally poke an unmapped index
    if ($urandom_range(0, 2) == 0)
      program_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
    settings_done++;
  endtask

  // One input item with an optional idle burst ahead of it
  task automatic send_sample(input int temp, input bit failed);
    int gap;
    gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, temp[14:0]};
    s_tuser  <= failed;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(temp[14:0], failed);
    @(negedge clk);
  endtask

  // Wait until the block is idle so registers may change
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h0100_0000);
    endcase
  endfunction

  task automatic randomize_settings();
    logic [31:0] sp;
    logic [31:0] lim;
    logic [31:0] per;
    sp = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 12500)) - 32'd4000;
    case ($urandom_range(0, 5))
      0:       lim = 32'd0;
      1:       lim = 32'hFFFF_FFFF;
      2:       lim = $urandom;
      default: lim = $urandom_range(0, 32'h0040_0000);
    endcase
    case ($urandom_range(0, 6))
      0:       per = 32'd0;
      1:       per = 32'hFFFF_FFFF;
      2:       per = $urandom;
      3:       per = 32'd1;
      default: per = $urandom_range(1, 2000000);
    endcase
    apply_all(sp, pick_gain(), pick_gain(), pick_gain(), lim, per);
  endtask

  // Result side: random ready stalls, none in the quiet phase
  initial begin
    int hold;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        m_tready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else if (m_tready && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        hold = $urandom_range(1, 10) - 1;
      end else begin
        m_tready <= 1'b1;
        hold = $urandom_range(0, 25);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Stimulus
  initial begin
    sb = new();
    quiet = 1'b0;
    settings_done = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: failed read before priming, priming, error extremes
    send_sample(32'h7FFF, 1'b1);
    send_sample(2500, 1'b0);
    send_sample(0, 1'b1);
    send_sample(-16384, 1'b0);
    send_sample(16383, 1'b0);
    send_sample(-4000, 1'b0);
    send_sample(8500, 1'b0);
    send_sample(3000, 1'b0);
    send_sample(3000, 1'b0);
    send_sample(3001, 1'b0);
    send_sample(2999, 1'b0);

    // everything at full scale, lowest setpoint: negative error saturation, capped products
    settle();
    apply_all(32'hFFFF_C000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    program_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    program_reg(REG_SPARE_HI, 32'h0000_0000);
    send_sample(16383, 1'b0);
    send_sample(-16384, 1'b0);
    send_sample(16383, 1'b0);
    send_sample(-4000, 1'b0);

    // zero period: duties stay at zero whatever the drive
    settle();
    apply_all(32'd8500, 32'd8589935, 32'd0, 32'd0, 32'd786432, 32'd0);
    send_sample(-4000, 1'b0);
    send_sample(8500, 1'b0);
    send_sample(16383, 1'b0);

    // zero limit, unit period, highest setpoint
    settle();
    apply_all(32'h0000_3FFF, 32'd4294967, 32'd858993, 32'h7FFF_FFFF, 32'd0, 32'd1);
    send_sample(-16384, 1'b0);
    send_sample(8500, 1'b0);
    send_sample(0, 1'b1);

    // random phases; the last one runs without idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      randomize_settings();
      if (ph == RAND_PHASES - 1) quiet = 1'b1;
      temp_walk = sb.setpoint + int'($urandom_range(0, 600)) - 300;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 19) == 0)
          send_sample(int'($urandom), $urandom_range(0, 9) == 0);
        else begin
          temp_walk = temp_walk + int'($urandom_range(0, 40)) - 20;
          send_sample(temp_walk, $urandom_range(0, 9) == 0);
        end
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples (%0d failed reads, %0d saturated errors) over %0d settings",
             sb.samples_taken, sb.skipped_reads, sb.saturated_errs, settings_done);
    $display("Checked %0d results, %0d with clamped drive, %0d mismatches",
             sb.results_seen, sb.clamped_drives, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("pid_heat_cool_pwm_controller test passed");
    end else begin
      $display("pid_heat_cool_pwm_controller test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", sb.pending_q.size());
    $display("pid_heat_cool_pwm_controller test failed");
    $finish;
  end
endmodule
